FILE: rtl/mlpp_pkg.sv
// package: constants, codes, row layout helpers and command type of the perceptron predictor
`default_nettype none
package mlpp_pkg;

    localparam int DEF_ROW_COUNT = 256;
    localparam int DEF_HIST_W    = 32;

    localparam int PC_W       = 64;
    localparam int SNAP_W     = 32;
    localparam int ROW_MAX_W  = 16;
    localparam int N_PERC     = 4;
    localparam int ROW_WTS    = 64;
    localparam int W_W        = 8;
    localparam int C_W        = 7;
    localparam int WMAX       = 127;
    localparam int CMAX       = 127;
    localparam int SCORE_W    = 14;
    localparam int N_CHUNK    = 8;
    localparam int ROW_W      = ROW_WTS * W_W + N_PERC * C_W;
    localparam int CONF_LSB   = ROW_WTS * W_W;
    localparam int FOLD_N     = 8;
    localparam int FOLD_BITS  = 8;

    typedef enum logic [1:0] {
        ACT_PREDICT = 2'd0,
        ACT_SHIFT   = 2'd1,
        ACT_TRAIN   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        t_action               act;
        logic [ROW_MAX_W-1:0]  row;
        logic                  taken;
        logic [SNAP_W-1:0]     snap;
    } t_cmd;

    function automatic int perc_base(input int p);
        case (p)
            0:       return 0;
            1:       return 5;
            2:       return 14;
            default: return 31;
        endcase
    endfunction

    function automatic int perc_thr(input int p);
        case (p)
            0:       return 22;
            1:       return 29;
            2:       return 45;
            default: return 76;
        endcase
    endfunction

    function automatic int perc_of(input int j);
        if (j < 5) begin
            return 0;
        end else if (j < 14) begin
            return 1;
        end else if (j < 31) begin
            return 2;
        end
        return 3;
    endfunction

    function automatic logic is_bias(input int j);
        return (j == 0) || (j == 5) || (j == 14) || (j == 31);
    endfunction

    function automatic int hist_idx(input int j);
        int b;
        b = perc_base(perc_of(j));
        return (j > b) ? (j - b - 1) : 0;
    endfunction

    function automatic int chunk_lo(input int k);
        case (k)
            0:       return 0;
            1:       return 5;
            2:       return 14;
            3:       return 22;
            4:       return 31;
            5:       return 39;
            6:       return 47;
            default: return 55;
        endcase
    endfunction

    function automatic int chunk_hi(input int k);
        return (k == N_CHUNK - 1) ? ROW_WTS : chunk_lo(k + 1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mlpp_if.sv
// interfaces: input and result channels of the perceptron predictor
`default_nettype none
interface mlpp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] pc;
    logic        taken;
    logic [31:0] snapshot_in;
    modport source(output valid, action, pc, taken, snapshot_in, input ready);
    modport sink(input valid, action, pc, taken, snapshot_in, output ready);
endinterface

interface mlpp_out_if;
    logic        valid;
    logic        ready;
    logic        predict_taken;
    logic        high_confidence;
    logic [1:0]  chosen_length;
    logic [31:0] snapshot_out;
    modport source(output valid, predict_taken, high_confidence, chosen_length, snapshot_out,
                   input ready);
    modport sink(input valid, predict_taken, high_confidence, chosen_length, snapshot_out,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/multi_length_perceptron_predictor.sv
// top level: multi-length perceptron branch predictor
//
//  channel   dir  handshake      word
//  i_in      in   valid/ready    action, pc, taken, snapshot_in
//  o_out     out  valid/ready    predict_taken, high_confidence, chosen_length, snapshot_out
//
//  after reset the row table is cleared, one row a cycle, no words taken
//  history shift: the front's push state and the queue lie before the history update; front free once pushed
//  predict and train: the front reduces the row (fold, quotient, remainder, fix) and pushes
//  the command to the queue; the back reads the row, sums it in two levels and writes the
//  result or the row update; the front takes the next such word once the command is pushed
//  a two-entry queue lets the front take the next word while the back works
//  a finished result waits in the output register without blocking history shifts
`default_nettype none
module multi_length_perceptron_predictor #(
    parameter int ROW_COUNT = mlpp_pkg::DEF_ROW_COUNT,
    parameter int HIST_W    = mlpp_pkg::DEF_HIST_W
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlpp_in_if.sink     i_in,
    mlpp_out_if.source  o_out
);
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_qvalid;
    logic            w_en;
    mlpp_pkg::t_cmd  w_fcmd;
    mlpp_pkg::t_cmd  w_qcmd;
    logic            w_bready;
    logic            r_run;

    // front starts taking words once the back has left table clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (w_bready) begin
            r_run <= 1'b1;
        end
    end
    assign w_en = r_run;

    mlpp_front #(
        .ROW_COUNT(ROW_COUNT)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_in   (i_in),
        .o_push (w_push),
        .o_cmd  (w_fcmd),
        .i_full (w_full)
    );

    mlpp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_fcmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qvalid),
        .o_cmd  (w_qcmd)
    );

    mlpp_back #(
        .ROW_COUNT(ROW_COUNT),
        .HIST_W   (HIST_W)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .o_ready(w_bready),
        .i_valid(w_qvalid),
        .i_cmd  (w_qcmd),
        .o_pop  (w_pop),
        .o_out  (o_out)
    );
endmodule
`default_nettype wire

FILE: rtl/mlpp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module mlpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/mlpp_front.sv
// front end: accepts words, reduces the address to a table row, hands commands on
`default_nettype none
module mlpp_front #(
    parameter int ROW_COUNT = mlpp_pkg::DEF_ROW_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    mlpp_in_if.sink          i_in,
    output logic             o_push,
    output mlpp_pkg::t_cmd   o_cmd,
    input  wire logic        i_full
);
    localparam int AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int SUM_W = 27;
    localparam int PRD_W = SUM_W + 28;
    localparam int QN_W  = SUM_W + 17;
    localparam int REM_W = 18;
    localparam int SHIFT = SUM_W + $clog2(ROW_COUNT);
    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'(ROW_COUNT);
    localparam logic [15:0] CHUNK_MOD [mlpp_pkg::FOLD_N] = '{
        16'((64'd1 << 0)  % 64'(ROW_COUNT)),
        16'((64'd1 << 8)  % 64'(ROW_COUNT)),
        16'((64'd1 << 16) % 64'(ROW_COUNT)),
        16'((64'd1 << 24) % 64'(ROW_COUNT)),
        16'((64'd1 << 32) % 64'(ROW_COUNT)),
        16'((64'd1 << 40) % 64'(ROW_COUNT)),
        16'((64'd1 << 48) % 64'(ROW_COUNT)),
        16'((64'd1 << 56) % 64'(ROW_COUNT))
    };

    typedef enum logic [2:0] {F_IDLE, F_FOLD, F_QUOT, F_REM, F_FIX, F_PUSH} t_fstate;

    t_fstate                   r_state;
    mlpp_pkg::t_cmd            r_cmd;
    logic [mlpp_pkg::PC_W-1:0] r_val;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_quo;
    logic [REM_W-1:0]          r_rem;
    logic [SUM_W-1:0]          n_sum;
    logic [PRD_W-1:0]          w_prod;
    logic [QN_W-1:0]           w_qn;
    logic [REM_W-1:0]          w_fix;
    mlpp_pkg::t_action         w_act;

    assign w_act      = mlpp_pkg::t_action'(i_in.action);
    assign i_in.ready = i_en && (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_cmd      = r_cmd;

    // address folded byte by byte, each byte weighted by its power of two mod the row count
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < mlpp_pkg::FOLD_N; k++) begin
            n_sum = n_sum + SUM_W'(r_val[k*mlpp_pkg::FOLD_BITS +: mlpp_pkg::FOLD_BITS])
                          * SUM_W'(CHUNK_MOD[k]);
        end
    end

    // quotient by reciprocal, low by at most one
    assign w_prod = PRD_W'(r_sum) * PRD_W'(RECIP[27:0]);
    assign w_qn   = QN_W'(r_quo) * QN_W'(ROW_COUNT);
    assign w_fix  = (r_rem >= REM_W'(ROW_COUNT)) ? r_rem - REM_W'(ROW_COUNT) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_cmd.act   <= w_act;
                        r_cmd.row   <= '0;
                        r_cmd.taken <= i_in.taken;
                        r_cmd.snap  <= i_in.snapshot_in;
                        r_val       <= {2'b00, i_in.pc[mlpp_pkg::PC_W-1:2]};
                        if (w_act == mlpp_pkg::ACT_SHIFT) begin
                            r_state <= F_PUSH;
                        end else if (w_act == mlpp_pkg::ACT_NONE) begin
                            r_state <= F_IDLE;
                        end else begin
                            r_state <= F_FOLD;
                        end
                    end
                end
                F_FOLD: begin
                    r_sum   <= n_sum;
                    r_state <= F_QUOT;
                end
                F_QUOT: begin
                    r_quo   <= SUM_W'(w_prod >> SHIFT);
                    r_state <= F_REM;
                end
                F_REM: begin
                    r_rem   <= REM_W'(QN_W'(r_sum) - w_qn);
                    r_state <= F_FIX;
                end
                F_FIX: begin
                    r_cmd.row <= mlpp_pkg::ROW_MAX_W'(w_fix[AW-1:0]);
                    r_state   <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_FIX) |-> (r_rem < REM_W'(2 * ROW_COUNT)))
        else $error("row remainder out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_cmd.act != mlpp_pkg::ACT_NONE))
        else $error("idle action forwarded");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_PUSH && i_full) |=> (r_state == F_PUSH && $stable(r_cmd)))
        else $error("pending command lost");
endmodule
`default_nettype wire

FILE: rtl/mlpp_queue.sv
// two-entry command queue between front and back
`default_nettype none
module mlpp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  mlpp_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output mlpp_pkg::t_cmd       o_cmd
);
    mlpp_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
endmodule
`default_nettype wire

FILE: rtl/mlpp_back.sv
// back end: table clear, row read, score tree, prediction and training
`default_nettype none
module mlpp_back #(
    parameter int ROW_COUNT = mlpp_pkg::DEF_ROW_COUNT,
    parameter int HIST_W    = mlpp_pkg::DEF_HIST_W
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    output logic             o_ready,
    input  wire logic        i_valid,
    input  mlpp_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    mlpp_out_if.source       o_out
);
    localparam int AW     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int THETA2 = 2 * ((193 * HIST_W + 1450) / 100);
    localparam int SW     = mlpp_pkg::SCORE_W;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SUM, S_SCORE, S_DO} t_bstate;

    t_bstate                     r_state;
    logic [AW-1:0]               r_clr;
    mlpp_pkg::t_cmd              r_cmd;
    logic [HIST_W-1:0]           r_hist;
    logic signed [SW-1:0]        r_part  [mlpp_pkg::N_CHUNK];
    logic signed [SW-1:0]        r_score [mlpp_pkg::N_PERC];
    logic                        r_ovalid;
    logic                        r_opt;
    logic                        r_ohc;
    logic [1:0]                  r_olen;
    logic [mlpp_pkg::SNAP_W-1:0] r_osnap;

    logic [mlpp_pkg::ROW_W-1:0]  w_rdata;
    logic [mlpp_pkg::ROW_W-1:0]  w_wdata;
    logic [mlpp_pkg::ROW_W-1:0]  w_new_row;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic                        w_re;
    logic [mlpp_pkg::SNAP_W-1:0] w_h;
    logic signed [SW-1:0]        w_term  [mlpp_pkg::ROW_WTS];
    logic signed [SW-1:0]        w_part  [mlpp_pkg::N_CHUNK];
    logic [1:0]                  w_best;
    logic                        w_train [mlpp_pkg::N_PERC];
    logic                        w_load;
    logic                        w_is_pred;

    assign o_ready   = (r_state == S_IDLE);
    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign w_re      = o_pop && (i_cmd.act != mlpp_pkg::ACT_SHIFT);
    assign w_is_pred = (r_cmd.act == mlpp_pkg::ACT_PREDICT);
    assign w_h       = w_is_pred ? r_hist[mlpp_pkg::SNAP_W-1:0] : r_cmd.snap;
    assign w_load    = (r_state == S_DO) && w_is_pred && (!r_ovalid || o_out.ready);
    assign w_we      = (r_state == S_CLEAR) || ((r_state == S_DO) && !w_is_pred);
    assign w_waddr   = (r_state == S_CLEAR) ? r_clr : r_cmd.row[AW-1:0];
    assign w_wdata   = (r_state == S_CLEAR) ? '0 : w_new_row;

    assign o_out.valid           = r_ovalid;
    assign o_out.predict_taken   = r_opt;
    assign o_out.high_confidence = r_ohc;
    assign o_out.chosen_length   = r_olen;
    assign o_out.snapshot_out    = r_osnap;

    mlpp_ram #(
        .WIDTH(mlpp_pkg::ROW_W),
        .DEPTH(ROW_COUNT)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(i_cmd.row[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // signed terms and partial sums of the row
    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] wv;
        for (int j = 0; j < mlpp_pkg::ROW_WTS; j++) begin
            wv = SW'($signed(w_rdata[j*mlpp_pkg::W_W +: mlpp_pkg::W_W]));
            if (mlpp_pkg::is_bias(j) || w_h[mlpp_pkg::hist_idx(j)]) begin
                w_term[j] = wv;
            end else begin
                w_term[j] = -wv;
            end
        end
        for (int k = 0; k < mlpp_pkg::N_CHUNK; k++) begin
            acc = '0;
            for (int j = 0; j < mlpp_pkg::ROW_WTS; j++) begin
                if (j >= mlpp_pkg::chunk_lo(k) && j < mlpp_pkg::chunk_hi(k)) begin
                    acc = acc + w_term[j];
                end
            end
            w_part[k] = acc;
        end
    end

    // chosen perceptron, ties to the longer history
    always_comb begin
        logic [mlpp_pkg::C_W-1:0] bc;
        logic [mlpp_pkg::C_W-1:0] c;
        w_best = 2'd0;
        bc     = w_rdata[mlpp_pkg::CONF_LSB +: mlpp_pkg::C_W];
        for (int p = 1; p < mlpp_pkg::N_PERC; p++) begin
            c = w_rdata[mlpp_pkg::CONF_LSB + p*mlpp_pkg::C_W +: mlpp_pkg::C_W];
            if (c >= bc) begin
                bc     = c;
                w_best = 2'(p);
            end
        end
    end

    // trained row
    always_comb begin
        logic signed [SW-1:0]      y;
        logic [SW-1:0]             ay;
        logic                      pred;
        logic [mlpp_pkg::C_W-1:0]  c;
        logic signed [9:0]         nw;
        logic                      up;
        int                        p;
        w_new_row = w_rdata;
        for (int q = 0; q < mlpp_pkg::N_PERC; q++) begin
            y    = r_score[q];
            pred = (y >= 0);
            ay   = (y < 0) ? SW'(-y) : SW'(y);
            w_train[q] = (pred != r_cmd.taken) || (ay <= SW'(mlpp_pkg::perc_thr(q)));
            c = w_rdata[mlpp_pkg::CONF_LSB + q*mlpp_pkg::C_W +: mlpp_pkg::C_W];
            if (pred == r_cmd.taken) begin
                if (c < mlpp_pkg::C_W'(mlpp_pkg::CMAX)) begin
                    c = c + 1'b1;
                end
            end else begin
                c = c >> 2;
            end
            w_new_row[mlpp_pkg::CONF_LSB + q*mlpp_pkg::C_W +: mlpp_pkg::C_W] = c;
        end
        for (int j = 0; j < mlpp_pkg::ROW_WTS; j++) begin
            p  = mlpp_pkg::perc_of(j);
            up = (mlpp_pkg::is_bias(j) || r_cmd.snap[mlpp_pkg::hist_idx(j)]) == r_cmd.taken;
            nw = 10'($signed(w_rdata[j*mlpp_pkg::W_W +: mlpp_pkg::W_W]));
            if (w_train[p]) begin
                nw = up ? nw + 10'sd1 : nw - 10'sd1;
                if (nw > 10'sd127) begin
                    nw = 10'sd127;
                end else if (nw < -10'sd127) begin
                    nw = -10'sd127;
                end
            end
            w_new_row[j*mlpp_pkg::W_W +: mlpp_pkg::W_W] = nw[mlpp_pkg::W_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [SW-1:0] as;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_hist   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(ROW_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.act == mlpp_pkg::ACT_SHIFT) begin
                            r_hist <= {r_hist[HIST_W-2:0], i_cmd.taken};
                        end else begin
                            r_cmd   <= i_cmd;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    for (int k = 0; k < mlpp_pkg::N_CHUNK; k++) begin
                        r_part[k] <= w_part[k];
                    end
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    r_score[0] <= r_part[0];
                    r_score[1] <= r_part[1];
                    r_score[2] <= r_part[2] + r_part[3];
                    r_score[3] <= r_part[4] + r_part[5] + r_part[6] + r_part[7];
                    r_state    <= S_DO;
                end
                S_DO: begin
                    if (!w_is_pred) begin
                        r_state <= S_IDLE;
                    end else if (w_load) begin
                        as = (r_score[w_best] < 0) ? SW'(-r_score[w_best]) : SW'(r_score[w_best]);
                        r_opt    <= (r_score[w_best] >= 0);
                        r_ohc    <= (as >= SW'(THETA2));
                        r_olen   <= w_best;
                        r_osnap  <= r_hist[mlpp_pkg::SNAP_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("table clear restarted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_DO))
        else $error("row write outside clear or update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ovalid || o_out.ready))
        else $error("result overwritten before taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("command taken while busy");
endmodule
`default_nettype wire
